FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge out of reset.
`define LFBP_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed: label");

// Checked on every clock edge, reset included.
`define LFBP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed: label");

`else

`define LFBP_ASSERT(label, clk, rstn, prop)
`define LFBP_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: design/lfbp_pkg.sv
// ----------------------------------------------------------------------------
// lfbp_pkg
// Types, constants and helpers for the latest-frame buffer pool.
// ----------------------------------------------------------------------------
`default_nettype none

package lfbp_pkg;

  localparam int POOL_SIZE  = 8;
  localparam int COUNT_BITS = 8;
  localparam int IDX_W      = $clog2(POOL_SIZE);
  localparam int FILL_W     = $clog2(POOL_SIZE + 1);

  localparam logic [1:0] REQ_ACQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_PUBLISH   = 2'd1;
  localparam logic [1:0] REQ_ACQ_READ  = 2'd2;
  localparam logic [1:0] REQ_RELEASE   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_COUNT = 2'd2;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [FILL_W-1:0]     fill_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam fill_t FILL_FULL = fill_t'(POOL_SIZE);
  localparam cnt_t  CNT_MAX   = '1;

  typedef struct packed {
    logic [1:0] req_type;
    idx_t       buffer_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    idx_t       granted_index;
    fill_t      free_count;
  } out_item_t;

  // free list control and status
  typedef struct packed {
    logic pop;
    logic push;
    idx_t push_idx;
  } fl_ctrl_t;

  typedef struct packed {
    idx_t  head_idx;
    fill_t fill;
    fill_t fill_nxt;
  } fl_stat_t;

  // reader count control
  typedef struct packed {
    idx_t addr;
    logic inc;
    logic dec;
  } rc_ctrl_t;

  function automatic idx_t ptr_next(input idx_t p);
    if (p == idx_t'(POOL_SIZE - 1)) begin
      return '0;
    end
    return p + idx_t'(1);
  endfunction

endpackage

`default_nettype wire

FILE: design/lfbp_free_list.sv
// ----------------------------------------------------------------------------
// lfbp_free_list
// FIFO of free buffer indices; full at reset with every index in order.
// ----------------------------------------------------------------------------
`default_nettype none

module lfbp_free_list (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lfbp_pkg::fl_ctrl_t ctrl,
  output lfbp_pkg::fl_stat_t      stat
);

  lfbp_pkg::idx_t  fifo_r [lfbp_pkg::POOL_SIZE];
  lfbp_pkg::idx_t  head_r;
  lfbp_pkg::idx_t  tail_r;
  lfbp_pkg::fill_t fill_r;
  lfbp_pkg::fill_t fill_nxt;
  logic            pop_ok;
  logic            push_ok;

  // full list drops the push
  assign pop_ok  = ctrl.pop && (fill_r != '0);
  assign push_ok = ctrl.push && (fill_r != lfbp_pkg::FILL_FULL);

  always_comb begin
    fill_nxt = fill_r;
    if (pop_ok) begin
      fill_nxt = fill_r - lfbp_pkg::fill_t'(1);
    end else if (push_ok) begin
      fill_nxt = fill_r + lfbp_pkg::fill_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lfbp_pkg::POOL_SIZE; i++) begin
        fifo_r[i] <= lfbp_pkg::idx_t'(i);
      end
      head_r <= '0;
      tail_r <= '0;
      fill_r <= lfbp_pkg::FILL_FULL;
    end else begin
      if (push_ok) begin
        fifo_r[tail_r] <= ctrl.push_idx;
        tail_r         <= lfbp_pkg::ptr_next(tail_r);
      end
      if (pop_ok) begin
        head_r <= lfbp_pkg::ptr_next(head_r);
      end
      fill_r <= fill_nxt;
    end
  end

  assign stat.head_idx = fifo_r[head_r];
  assign stat.fill     = fill_r;
  assign stat.fill_nxt = fill_nxt;

endmodule

`default_nettype wire

FILE: design/lfbp_ref_counts.sv
// ----------------------------------------------------------------------------
// lfbp_ref_counts
// Per-buffer reader counts, one read/update port, cleared at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lfbp_ref_counts (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lfbp_pkg::rc_ctrl_t ctrl,
  output lfbp_pkg::cnt_t          rd_cnt
);

  lfbp_pkg::cnt_t cnt_r [lfbp_pkg::POOL_SIZE];

  assign rd_cnt = cnt_r[ctrl.addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lfbp_pkg::POOL_SIZE; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (ctrl.inc) begin
      cnt_r[ctrl.addr] <= rd_cnt + lfbp_pkg::cnt_t'(1);
    end else if (ctrl.dec) begin
      cnt_r[ctrl.addr] <= rd_cnt - lfbp_pkg::cnt_t'(1);
    end
  end

endmodule

`default_nettype wire

FILE: design/latest_frame_buffer_pool.sv
// ----------------------------------------------------------------------------
// latest_frame_buffer_pool
// Frame buffer pool: FIFO free list, latest-frame tracking, reader counts.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per handshake (acquire write, publish, acquire read,
//           release read) with a buffer index for publish and release.
//   out_* : exactly one result per request, in request order: status,
//           granted index (zero unless an acquire succeeds), free-list fill.
//   Flow: an accepted request is captured in the input register, resolved
//   combinationally against the pool state, then registered as its result.
//   Throughput: one request per cycle unless the receiver stalls; the state
//   update (one free-list slot and one reader count per request) sets this figure.
//   Reset (rst_n low, synchronous): free list holds every index in order,
//   reader counts clear, no latest frame, both pipeline registers empty.
//   Receiver stall: the result stays in the output register; one more
//   request is held in the input register, then in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module latest_frame_buffer_pool (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lfbp_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lfbp_pkg::out_item_t      out_data
);

  lfbp_pkg::in_item_t  in_r;
  logic                in_vld_r;
  lfbp_pkg::out_item_t out_r;
  lfbp_pkg::out_item_t out_nxt;
  logic                out_vld_r;
  logic                latest_valid_r;
  lfbp_pkg::idx_t      latest_index_r;
  logic                latest_valid_nxt;
  lfbp_pkg::idx_t      latest_index_nxt;
  logic                go;
  logic                in_range;
  logic                cnt_zero;
  logic                cnt_one;
  logic                cnt_max;
  lfbp_pkg::cnt_t      rd_cnt;
  lfbp_pkg::fl_ctrl_t  fl_ctrl;
  lfbp_pkg::fl_stat_t  fl_stat;
  lfbp_pkg::rc_ctrl_t  rc_ctrl;

  assign go       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || go;

  lfbp_free_list u_free_list (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (fl_ctrl),
    .stat  (fl_stat)
  );

  lfbp_ref_counts u_ref_counts (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (rc_ctrl),
    .rd_cnt (rd_cnt)
  );

  assign in_range = int'(in_r.buffer_index) < lfbp_pkg::POOL_SIZE;
  assign cnt_zero = (rd_cnt == '0);
  assign cnt_one  = (rd_cnt == lfbp_pkg::cnt_t'(1));
  assign cnt_max  = (rd_cnt == lfbp_pkg::CNT_MAX);

  always_comb begin
    fl_ctrl          = '0;
    rc_ctrl          = '0;
    rc_ctrl.addr     = (in_r.req_type == lfbp_pkg::REQ_RELEASE) ?
                       in_r.buffer_index : latest_index_r;
    latest_valid_nxt = latest_valid_r;
    latest_index_nxt = latest_index_r;
    out_nxt          = '0;
    out_nxt.status   = lfbp_pkg::ST_OK;
    case (in_r.req_type)
      lfbp_pkg::REQ_ACQ_WRITE: begin
        if (fl_stat.fill == '0) begin
          out_nxt.status = lfbp_pkg::ST_NONE;
        end else begin
          fl_ctrl.pop           = go;
          out_nxt.granted_index = fl_stat.head_idx;
        end
      end
      lfbp_pkg::REQ_PUBLISH: begin
        if (in_range) begin
          fl_ctrl.push     = go && latest_valid_r && cnt_zero;
          fl_ctrl.push_idx = latest_index_r;
          latest_valid_nxt = 1'b1;
          latest_index_nxt = in_r.buffer_index;
        end
      end
      lfbp_pkg::REQ_ACQ_READ: begin
        if (!latest_valid_r) begin
          out_nxt.status = lfbp_pkg::ST_NONE;
        end else if (cnt_max) begin
          out_nxt.status = lfbp_pkg::ST_COUNT;
        end else begin
          rc_ctrl.inc           = go;
          out_nxt.granted_index = latest_index_r;
        end
      end
      lfbp_pkg::REQ_RELEASE: begin
        if (in_range) begin
          if (cnt_zero) begin
            out_nxt.status = lfbp_pkg::ST_COUNT;
          end else begin
            rc_ctrl.dec      = go;
            fl_ctrl.push     = go && cnt_one &&
                               !(latest_valid_r && latest_index_r == in_r.buffer_index);
            fl_ctrl.push_idx = in_r.buffer_index;
          end
        end
      end
      default: begin
        out_nxt.status = lfbp_pkg::ST_OK;
      end
    endcase
    out_nxt.free_count = fl_stat.fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
      latest_valid_r <= 1'b0;
      latest_index_r <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (go) begin
        out_vld_r      <= 1'b1;
        latest_valid_r <= latest_valid_nxt;
        latest_index_r <= latest_index_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (go) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `LFBP_ASSERT(a_fill_bound, clk, rst_n, fl_stat.fill <= lfbp_pkg::FILL_FULL)
  `LFBP_ASSERT(a_go_gives_result, clk, rst_n, go |=> out_valid)
  `LFBP_ASSERT(a_no_grant_on_fail, clk, rst_n, (out_valid && out_data.status != lfbp_pkg::ST_OK) |-> (out_data.granted_index == '0))
  `LFBP_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!out_valid && in_ready))

endmodule

`default_nettype wire

FILE: tb/pool_checker.sv
// ----------------------------------------------------------------------------
// pool_checker
// Watches both channels of the frame buffer pool, tracks the free list, the
// latest frame and the reader counts for every accepted request, and checks
// each result field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pool_checker
  import lfbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        errors,
  output int        outstanding
);

  idx_t      free_list [POOL_SIZE];
  idx_t      free_head;
  idx_t      free_tail;
  fill_t     free_fill;
  cnt_t      readers [POOL_SIZE];
  logic      latest_valid;
  idx_t      latest_buf;
  out_item_t pending_results [$];
  int        result_no;

  initial begin
    errors = 0;
    outstanding = 0;
  end

  function automatic idx_t wrap_next(input idx_t p);
    return idx_t'((int'(p) + 1) % POOL_SIZE);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    $display("pool_checker: result %0d %s: got %0h want %0h", result_no, what, got, want);
  endtask

  // push is dropped when the list is already full
  task automatic return_to_free(input idx_t b);
    if (free_fill < FILL_FULL) begin
      free_list[free_tail] = b;
      free_tail = wrap_next(free_tail);
      free_fill++;
    end
  endtask

  task automatic serve_request(input in_item_t req, output out_item_t res);
    idx_t b;
    b = req.buffer_index;
    res = '0;
    res.status = ST_OK;
    case (req.req_type)
      REQ_ACQ_WRITE: begin
        if (free_fill == '0) begin
          res.status = ST_NONE;
        end else begin
          res.granted_index = free_list[free_head];
          free_head = wrap_next(free_head);
          free_fill--;
        end
      end
      REQ_PUBLISH: begin
        if (int'(b) < POOL_SIZE) begin
          if (latest_valid && readers[latest_buf] == '0) begin
            return_to_free(latest_buf);
          end
          latest_valid = 1'b1;
          latest_buf = b;
        end
      end
      REQ_ACQ_READ: begin
        if (!latest_valid) begin
          res.status = ST_NONE;
        end else if (readers[latest_buf] == CNT_MAX) begin
          res.status = ST_COUNT;
        end else begin
          readers[latest_buf]++;
          res.granted_index = latest_buf;
        end
      end
      default: begin
        if (int'(b) < POOL_SIZE) begin
          if (readers[b] == '0) begin
            res.status = ST_COUNT;
          end else begin
            readers[b]--;
            if (readers[b] == '0 && !(latest_valid && latest_buf == b)) begin
              return_to_free(b);
            end
          end
        end
      end
    endcase
    res.free_count = free_fill;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      for (int i = 0; i < POOL_SIZE; i++) begin
        free_list[i] = idx_t'(i);
        readers[i] = '0;
      end
      free_head = '0;
      free_tail = '0;
      free_fill = FILL_FULL;
      latest_valid = 1'b0;
      latest_buf = '0;
      pending_results.delete();
      result_no = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request outstanding, status", 8'(got.status), 8'h0);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (got.status !== want.status) begin
            report_mismatch("status", 8'(got.status), 8'(want.status));
          end
          if (got.granted_index !== want.granted_index) begin
            report_mismatch("granted_index", 8'(got.granted_index), 8'(want.granted_index));
          end
          if (got.free_count !== want.free_count) begin
            report_mismatch("free_count", 8'(got.free_count), 8'(want.free_count));
          end
        end
        result_no++;
      end
      if (in_valid && in_ready) begin
        serve_request(in_data, want);
        pending_results = {pending_results, want};
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the frame buffer pool with a directed opener, a reader count
// saturation run and random writer/reader traffic built from granted
// indices, under bursty sending and a shifting receiver stall pattern.
// ----------------------------------------------------------------------------
module testbench;
  import lfbp_pkg::*;

  localparam int RANDOM_REQUESTS = 120;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int RX_STREAM       = 0;
  localparam int RX_CHOPPY       = 1;
  localparam int RX_SLOW         = 2;

  typedef struct packed {
    logic       keep;
    logic [1:0] kind;
  } sent_req_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        errors;
  int        outstanding;
  int        cycle_count = 0;
  int        burst_left = 0;
  int        rx_mode = RX_STREAM;
  int        rx_left = 0;
  logic      track_grants = 1'b1;
  idx_t      written_bufs [$];
  idx_t      read_bufs [$];
  sent_req_t sent_reqs [$];

  latest_frame_buffer_pool uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  pool_checker pool_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(RX_STREAM, RX_SLOW);
      rx_left <= $urandom_range(20, 150);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_STREAM: out_ready <= 1'b1;
      RX_CHOPPY: out_ready <= ($urandom_range(0, 1) == 1);
      default:   out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // granted indices feed later publishes and releases; sampled mid-cycle,
  // where the upcoming edge's handshakes are already settled
  always @(negedge clk) begin
    sent_req_t done;
    sent_req_t fresh;
    if (rst_n) begin
      if (out_valid && out_ready && sent_reqs.size() > 0) begin
        done = sent_reqs[0];
        sent_reqs.delete(0);
        if (done.keep && out_data.status == ST_OK) begin
          if (done.kind == REQ_ACQ_WRITE) begin
            written_bufs = {written_bufs, out_data.granted_index};
          end else if (done.kind == REQ_ACQ_READ) begin
            read_bufs = {read_bufs, out_data.granted_index};
          end
        end
      end
      if (in_valid && in_ready) begin
        fresh.keep = track_grants;
        fresh.kind = in_data.req_type;
        sent_reqs = {sent_reqs, fresh};
      end
    end
  end

  task automatic send_request(input logic [1:0] kind, input idx_t b);
    in_item_t r;
    r.req_type = kind;
    r.buffer_index = b;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 16);
    end else begin
      burst_left--;
    end
  endtask

  // mostly writer/reader flow on granted indices, some noise
  task automatic pick_request(output logic [1:0] kind, output idx_t b);
    int roll;
    int k;
    roll = $urandom_range(0, 99);
    kind = REQ_ACQ_WRITE;
    b = idx_t'($urandom_range(0, POOL_SIZE - 1));
    if (roll < 10) begin
      kind = 2'($urandom_range(0, 3));
    end else if (roll < 30) begin
      kind = REQ_ACQ_WRITE;
    end else if (roll < 50) begin
      if (written_bufs.size() > 0) begin
        kind = REQ_PUBLISH;
        b = written_bufs[0];
        written_bufs.delete(0);
      end
    end else if (roll < 75 || read_bufs.size() == 0) begin
      kind = REQ_ACQ_READ;
    end else begin
      k = $urandom_range(0, read_bufs.size() - 1);
      kind = REQ_RELEASE;
      b = read_bufs[k];
      read_bufs.delete(k);
    end
  endtask

  initial begin
    idx_t       stress_buf;
    logic [1:0] kind;
    idx_t       b;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_request(REQ_ACQ_READ, idx_t'(0));
    send_request(REQ_RELEASE, idx_t'(0));
    send_request(REQ_PUBLISH, idx_t'(3));
    send_request(REQ_PUBLISH, idx_t'(5));
    repeat (POOL_SIZE + 1) send_request(REQ_ACQ_WRITE, idx_t'(7));
    send_request(REQ_ACQ_READ, idx_t'(7));
    send_request(REQ_PUBLISH, idx_t'(7));
    send_request(REQ_RELEASE, idx_t'(5));
    send_request(REQ_PUBLISH, idx_t'(7));
    send_request(REQ_ACQ_WRITE, idx_t'(0));
    send_request(REQ_RELEASE, idx_t'(7));
    send_request(REQ_ACQ_READ, idx_t'(0));
    send_request(REQ_RELEASE, idx_t'(7));
    send_request(REQ_PUBLISH, idx_t'(0));
    send_request(REQ_RELEASE, idx_t'(6));

    // drive one reader count into saturation, then step it down once
    track_grants <= 1'b0;
    stress_buf = idx_t'($urandom_range(0, POOL_SIZE - 1));
    send_request(REQ_PUBLISH, stress_buf);
    repeat (int'(CNT_MAX) + 1) send_request(REQ_ACQ_READ, stress_buf);
    send_request(REQ_RELEASE, stress_buf);
    track_grants <= 1'b1;

    repeat (RANDOM_REQUESTS) begin
      pick_request(kind, b);
      send_request(kind, b);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/lfbp_pkg.sv
design/lfbp_free_list.sv
design/lfbp_ref_counts.sv
design/latest_frame_buffer_pool.sv
tb/pool_checker.sv
tb/testbench.sv
